FILE: src/bbt_pkg.sv
package bbt_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int PRICE_BITS = 24;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int PER_W      = 9;
  localparam int BW_W       = 8;
  localparam int SUM_W      = 32;
  localparam int SQ_W       = 56;
  localparam int MID_W      = 32;
  localparam int BAND_W     = 41;
  localparam int OFF_W      = 36;
  localparam int SIG_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int DIV_W      = 64;
  localparam int DIV_RW     = 17;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  localparam int ROOT_W     = 32;
  localparam int ROOT_RW    = 34;
  localparam int ROOT_CNT_W = $clog2(ROOT_W);

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BANDW  = 2'd1;

  typedef enum logic [SIG_W-1:0] {
    SIG_NONE       = 3'd0,
    SIG_OVERBOUGHT = 3'd1,
    SIG_OVERSOLD   = 3'd2,
    SIG_BULLISH    = 3'd3,
    SIG_BEARISH    = 3'd4
  } signal_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_NEW,
    S_SQ_OLD,
    S_SQ_DROP,
    S_MUL_HI,
    S_MUL_LO,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ROOT_WAIT,
    S_SCALE,
    S_EMIT
  } state_e;

endpackage

FILE: src/bbt_serial_div.sv
module bbt_serial_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bbt_pkg::DIV_RW-1:0] rem_init_i,
  input  logic [bbt_pkg::DIV_W-1:0]  dividend_i,
  input  logic [bbt_pkg::DIV_RW-1:0] divisor_i,
  output logic [bbt_pkg::DIV_W-1:0]  quotient_o,
  output logic                       done_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [bbt_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [bbt_pkg::DIV_RW-1:0]    rem_q;
  logic [bbt_pkg::DIV_W-1:0]     q_q;
  logic [bbt_pkg::DIV_RW-1:0]    div_q;
  logic [bbt_pkg::DIV_RW:0]      trial;
  logic [bbt_pkg::DIV_RW:0]      diff;
  logic                          ge;

  always_comb begin
    trial = {rem_q, q_q[bbt_pkg::DIV_W-1]};
    ge    = trial >= {1'b0, div_q};
    diff  = trial - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      q_q   <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[bbt_pkg::DIV_RW-1:0] : trial[bbt_pkg::DIV_RW-1:0];
      q_q   <= {q_q[bbt_pkg::DIV_W-2:0], ge};
    end
  end

  assign quotient_o = q_q;
  assign done_o     = done_q;

endmodule

FILE: src/bbt_serial_sqrt.sv
module bbt_serial_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bbt_pkg::DIV_W-1:0]  radicand_i,
  output logic [bbt_pkg::ROOT_W-1:0] root_o,
  output logic                       done_o
);

  logic                           busy_q;
  logic                           done_q;
  logic [bbt_pkg::ROOT_CNT_W-1:0] cnt_q;
  logic [bbt_pkg::ROOT_RW-1:0]    rem_q;
  logic [bbt_pkg::DIV_W-1:0]      x_q;
  logic [bbt_pkg::ROOT_W-1:0]     root_q;
  logic [bbt_pkg::ROOT_RW+1:0]    trial;
  logic [bbt_pkg::ROOT_RW+1:0]    sub;
  logic [bbt_pkg::ROOT_RW+1:0]    diff;
  logic                           ge;

  always_comb begin
    trial = {rem_q, x_q[bbt_pkg::DIV_W-1 -: 2]};
    sub   = {2'b00, root_q, 2'b01};
    ge    = trial >= sub;
    diff  = trial - sub;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      x_q    <= radicand_i;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[bbt_pkg::ROOT_RW-1:0] : trial[bbt_pkg::ROOT_RW-1:0];
      x_q    <= {x_q[bbt_pkg::DIV_W-3:0], 2'b00};
      root_q <= {root_q[bbt_pkg::ROOT_W-2:0], ge};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

FILE: src/bollinger_band_tracker.sv
// channel  direction  handshake                    payload
// in       input      in_valid_i / in_ready_o      close_price_i, start_series_i
// out      output     out_valid_o / out_ready_i    middle_band_o, band_up_o,
//                                                  band_dn_o, band_signal_o
// cfg      input      cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// A request with a full window runs in order: update the sums and form the products,
// divide in the bit-serial variance divider (the mean divider runs beside it), take the
// bit-serial root, scale and emit, then return to idle before the next request is accepted.
// While the window is filling a request skips the dividers and the root and goes to emit.
// Reset sets the period to 20, the band width to 32 sixteenths and clears history.
// A result waits in the output register; EMIT holds until the output register is free.
// Config is taken only in idle and a pending config write holds off the in channel.
module bollinger_band_tracker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bbt_pkg::PRICE_BITS-1:0]     close_price_i,
  input  logic                               start_series_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [bbt_pkg::MID_W-1:0]          middle_band_o,
  output logic signed [bbt_pkg::BAND_W-1:0]  band_up_o,
  output logic signed [bbt_pkg::BAND_W-1:0]  band_dn_o,
  output logic [bbt_pkg::SIG_W-1:0]          band_signal_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bbt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bbt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  bbt_pkg::state_e state_q, state_d;

  logic [bbt_pkg::PER_W-1:0]      per_q;
  logic [bbt_pkg::BW_W-1:0]       bw_q;
  logic [bbt_pkg::PER_W-1:0]      seen_q;
  logic [bbt_pkg::SLOT_W-1:0]     slot_q;
  logic [bbt_pkg::SUM_W-1:0]      sum_q;
  logic [bbt_pkg::SQ_W-1:0]       sq_q;
  logic [bbt_pkg::PRICE_BITS-1:0] ring_q [bbt_pkg::MAX_WINDOW];

  logic [bbt_pkg::PRICE_BITS-1:0]   price_q;
  logic [bbt_pkg::PRICE_BITS-1:0]   old_q;
  logic                             full_q;
  logic                             insuf_q;
  logic [2*bbt_pkg::PRICE_BITS-1:0] prod_q;
  logic [bbt_pkg::DIV_W-1:0]        hi_q;
  logic [bbt_pkg::DIV_W-1:0]        lo_q;
  logic [bbt_pkg::DIV_RW-1:0]       pp_q;
  logic [bbt_pkg::MID_W-1:0]        mid_q;
  logic [bbt_pkg::ROOT_W-1:0]       dev_q;
  logic [bbt_pkg::OFF_W-1:0]        off_q;

  logic                             out_valid_q;
  logic [bbt_pkg::MID_W-1:0]        out_mid_q;
  logic signed [bbt_pkg::BAND_W-1:0] out_up_q;
  logic signed [bbt_pkg::BAND_W-1:0] out_dn_q;
  bbt_pkg::signal_e                 out_sig_q;

  logic                             accept;
  logic                             cfg_wr;
  logic [bbt_pkg::PER_W-1:0]        seen_eff;
  logic [bbt_pkg::SLOT_W-1:0]       slot_eff;
  logic                             full_now;
  logic [bbt_pkg::PER_W-1:0]        seen_nx;
  logic [bbt_pkg::SLOT_W-1:0]       old_addr;
  logic [bbt_pkg::PER_W-1:0]        per_new;
  logic [bbt_pkg::PRICE_BITS-1:0]   mul_a;
  logic [bbt_pkg::DIV_W:0]          hi_full;
  logic [2*bbt_pkg::PER_W-1:0]      pp_full;
  logic [bbt_pkg::DIV_W-1:0]        d_val;
  logic [bbt_pkg::ROOT_W+bbt_pkg::BW_W-1:0] scaled;
  logic                             div_start;
  logic                             root_start;
  logic                             out_load;
  logic [bbt_pkg::DIV_W-1:0]        var_quo;
  logic [bbt_pkg::DIV_W-1:0]        mid_quo;
  logic                             var_done;
  logic                             mid_done;
  logic [bbt_pkg::ROOT_W-1:0]       root;
  logic                             root_done;
  logic signed [bbt_pkg::BAND_W-1:0] up_w;
  logic signed [bbt_pkg::BAND_W-1:0] dn_w;
  logic [bbt_pkg::MID_W-1:0]        c_w;
  bbt_pkg::signal_e                 sig_w;

  assign in_ready_o  = (state_q == bbt_pkg::S_IDLE) & ~cfg_valid_i;
  assign cfg_ready_o = (state_q == bbt_pkg::S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    seen_eff = start_series_i ? '0 : seen_q;
    slot_eff = start_series_i ? '0 : slot_q;
    full_now = seen_eff >= per_q;
    seen_nx  = full_now ? seen_eff : seen_eff + 1'b1;
    old_addr = slot_eff - per_q[bbt_pkg::SLOT_W-1:0];
    per_new  = cfg_data_i;
    if (per_new == '0) begin
      per_new = bbt_pkg::PER_W'(1);
    end else if (per_new > bbt_pkg::PER_W'(bbt_pkg::MAX_WINDOW)) begin
      per_new = bbt_pkg::PER_W'(bbt_pkg::MAX_WINDOW);
    end
  end

  always_comb begin
    mul_a   = (state_q == bbt_pkg::S_SQ_NEW) ? price_q : old_q;
    hi_full = (bbt_pkg::DIV_W+1)'(per_q) * (bbt_pkg::DIV_W+1)'(sq_q);
    pp_full = per_q * per_q;
    d_val   = (hi_q >= lo_q) ? hi_q - lo_q : '0;
    scaled  = bw_q * dev_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_q[slot_eff] <= close_price_i;
      old_q            <= ring_q[old_addr];
    end
  end

  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    root_start = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      bbt_pkg::S_IDLE: begin
        if (accept) state_d = bbt_pkg::S_SQ_NEW;
      end
      bbt_pkg::S_SQ_NEW:  state_d = bbt_pkg::S_SQ_OLD;
      bbt_pkg::S_SQ_OLD:  state_d = bbt_pkg::S_SQ_DROP;
      bbt_pkg::S_SQ_DROP: state_d = insuf_q ? bbt_pkg::S_EMIT : bbt_pkg::S_MUL_HI;
      bbt_pkg::S_MUL_HI:  state_d = bbt_pkg::S_MUL_LO;
      bbt_pkg::S_MUL_LO:  state_d = bbt_pkg::S_DIV_GO;
      bbt_pkg::S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = bbt_pkg::S_DIV_WAIT;
      end
      bbt_pkg::S_DIV_WAIT: begin
        if (var_done) begin
          root_start = 1'b1;
          state_d    = bbt_pkg::S_ROOT_WAIT;
        end
      end
      bbt_pkg::S_ROOT_WAIT: begin
        if (root_done) state_d = bbt_pkg::S_SCALE;
      end
      bbt_pkg::S_SCALE: state_d = bbt_pkg::S_EMIT;
      bbt_pkg::S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = bbt_pkg::S_IDLE;
        end
      end
      default: state_d = bbt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_q  <= bbt_pkg::PER_W'(20);
      bw_q   <= bbt_pkg::BW_W'(32);
      seen_q <= '0;
      slot_q <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
    end else begin
      if (cfg_wr) begin
        if (cfg_index_i == bbt_pkg::REG_PERIOD) begin
          per_q  <= per_new;
          seen_q <= '0;
          slot_q <= '0;
          sum_q  <= '0;
          sq_q   <= '0;
        end else if (cfg_index_i == bbt_pkg::REG_BANDW) begin
          bw_q <= cfg_data_i[bbt_pkg::BW_W-1:0];
        end
      end
      if (accept) begin
        seen_q <= seen_nx;
        slot_q <= slot_eff + 1'b1;
        if (start_series_i) begin
          sum_q <= '0;
          sq_q  <= '0;
        end
      end
      if (state_q == bbt_pkg::S_SQ_OLD) begin
        sum_q <= sum_q + bbt_pkg::SUM_W'(price_q)
                 - (full_q ? bbt_pkg::SUM_W'(old_q) : '0);
        sq_q  <= sq_q + bbt_pkg::SQ_W'(prod_q);
      end
      if (state_q == bbt_pkg::S_SQ_DROP && full_q) begin
        sq_q <= sq_q - bbt_pkg::SQ_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      price_q <= close_price_i;
      full_q  <= full_now;
      insuf_q <= seen_nx < per_q;
    end
    if (state_q == bbt_pkg::S_SQ_NEW || state_q == bbt_pkg::S_SQ_OLD) begin
      prod_q <= mul_a * mul_a;
    end
    if (state_q == bbt_pkg::S_MUL_HI) begin
      hi_q <= hi_full[bbt_pkg::DIV_W-1:0];
      pp_q <= pp_full[bbt_pkg::DIV_RW-1:0];
    end
    if (state_q == bbt_pkg::S_MUL_LO) begin
      lo_q <= bbt_pkg::DIV_W'(sum_q) * bbt_pkg::DIV_W'(sum_q);
    end
    if (mid_done) begin
      mid_q <= mid_quo[bbt_pkg::MID_W-1:0];
    end
    if (root_done) begin
      dev_q <= root;
    end
    if (state_q == bbt_pkg::S_SCALE) begin
      off_q <= scaled[bbt_pkg::OFF_W+3:4];
    end
  end

  bbt_serial_div u_var_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i ({1'b0, d_val[bbt_pkg::DIV_W-1 -: bbt_pkg::DIV_RW-1]}),
    .dividend_i ({d_val[bbt_pkg::DIV_W-bbt_pkg::DIV_RW:0], 16'h0000}),
    .divisor_i  (pp_q),
    .quotient_o (var_quo),
    .done_o     (var_done)
  );

  bbt_serial_div u_mid_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i ('0),
    .dividend_i ({24'h000000, sum_q, 8'h00}),
    .divisor_i  (bbt_pkg::DIV_RW'(per_q)),
    .quotient_o (mid_quo),
    .done_o     (mid_done)
  );

  bbt_serial_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (var_quo),
    .root_o     (root),
    .done_o     (root_done)
  );

  always_comb begin
    up_w = $signed(bbt_pkg::BAND_W'(mid_q)) + $signed(bbt_pkg::BAND_W'(off_q));
    dn_w = $signed(bbt_pkg::BAND_W'(mid_q)) - $signed(bbt_pkg::BAND_W'(off_q));
    c_w  = {price_q, 8'h00};
    if ($signed(bbt_pkg::BAND_W'(c_w)) > up_w) begin
      sig_w = bbt_pkg::SIG_OVERBOUGHT;
    end else if (off_q <= bbt_pkg::OFF_W'(mid_q) &&
                 $signed(bbt_pkg::BAND_W'(c_w)) < dn_w) begin
      sig_w = bbt_pkg::SIG_OVERSOLD;
    end else if (c_w > mid_q) begin
      sig_w = bbt_pkg::SIG_BULLISH;
    end else begin
      sig_w = bbt_pkg::SIG_BEARISH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (insuf_q) begin
        out_mid_q <= '0;
        out_up_q  <= '0;
        out_dn_q  <= '0;
        out_sig_q <= bbt_pkg::SIG_NONE;
      end else begin
        out_mid_q <= mid_q;
        out_up_q  <= up_w;
        out_dn_q  <= dn_w;
        out_sig_q <= sig_w;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign middle_band_o = out_mid_q;
  assign band_up_o     = out_up_q;
  assign band_dn_o     = out_dn_q;
  assign band_signal_o = out_sig_q;

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= per_q)
    else $error("prices seen exceeds period");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    var_done == mid_done)
    else $error("dividers out of step");

  a_band_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && band_signal_o != bbt_pkg::SIG_NONE |-> band_dn_o <= band_up_o)
    else $error("lower band above upper band");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && band_signal_o == bbt_pkg::SIG_NONE |-> middle_band_o == '0)
    else $error("insufficient result carries a band");

endmodule

FILE: verif/tb_bollinger_band_tracker.sv
`timescale 1ns / 100ps

module tb_bollinger_band_tracker;

  typedef struct {
    logic [bbt_pkg::MID_W-1:0]         mid;
    logic signed [bbt_pkg::BAND_W-1:0] up;
    logic signed [bbt_pkg::BAND_W-1:0] dn;
    bbt_pkg::signal_e                  sig;
  } band_t;

  typedef struct {
    bit                               is_cfg;
    logic [bbt_pkg::CFG_IDX_W-1:0]    idx;
    logic [bbt_pkg::CFG_DATA_W-1:0]   data;
    logic [bbt_pkg::PRICE_BITS-1:0]   price;
    logic                             start;
    bit                               fixed;
    band_t                            res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [bbt_pkg::PRICE_BITS-1:0] close_price_i = '0;
  logic start_series_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [bbt_pkg::MID_W-1:0] middle_band_o;
  logic signed [bbt_pkg::BAND_W-1:0] band_up_o;
  logic signed [bbt_pkg::BAND_W-1:0] band_dn_o;
  logic [bbt_pkg::SIG_W-1:0] band_signal_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [bbt_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [bbt_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  bollinger_band_tracker u_dut (.*);

  logic [bbt_pkg::PRICE_BITS-1:0] ring_m [bbt_pkg::MAX_WINDOW];
  logic [63:0] sum_m, sq_m;
  int unsigned seen_m;
  logic [bbt_pkg::SLOT_W-1:0] slot_m;
  int unsigned period_m = 20;
  logic [63:0] bw_m = 64'd32;

  band_t band_q[$];
  row_t rows[$];
  int errors = 0;
  bit quiet = 0;
  int unsigned out_stall = 0;
  longint cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void clear_series();
    sum_m = 0;
    sq_m = 0;
    seen_m = 0;
    slot_m = 0;
  endfunction

  function automatic void apply_cfg(logic [bbt_pkg::CFG_IDX_W-1:0] idx,
                                    logic [bbt_pkg::CFG_DATA_W-1:0] data);
    if (idx == bbt_pkg::REG_PERIOD) begin
      period_m = (data == 0) ? 1 :
                 (data > bbt_pkg::MAX_WINDOW) ? bbt_pkg::MAX_WINDOW : int'(data);
      clear_series();
    end else if (idx == bbt_pkg::REG_BANDW) begin
      bw_m = 64'(data[bbt_pkg::BW_W-1:0]);
    end
  endfunction

  function automatic band_t predict_band(logic [bbt_pkg::PRICE_BITS-1:0] price, logic start);
    band_t b;
    logic [63:0] pr, p, ov, mid, hi, lo, d, pp, v16, dev, off, up, dn, c;
    logic [bbt_pkg::SLOT_W-1:0] old;
    pr = 64'(price);
    p = 64'(period_m);
    if (start) clear_series();
    if (seen_m >= period_m) begin
      old = slot_m - period_m[bbt_pkg::SLOT_W-1:0];
      ov = 64'(ring_m[old]);
      sum_m -= ov;
      sq_m -= ov * ov;
    end else begin
      seen_m++;
    end
    ring_m[slot_m] = price;
    sum_m += pr;
    sq_m += pr * pr;
    slot_m++;
    b.mid = '0;
    b.up = '0;
    b.dn = '0;
    b.sig = bbt_pkg::SIG_NONE;
    if (seen_m < period_m) return b;
    mid = (sum_m * 256) / p;
    hi = p * sq_m;
    lo = sum_m * sum_m;
    d = (hi >= lo) ? hi - lo : 0;
    pp = p * p;
    v16 = (d / pp) * 65536 + ((d % pp) * 65536) / pp;
    dev = isqrt(v16);
    off = (bw_m * dev) >> 4;
    up = mid + off;
    dn = mid - off;
    c = pr * 256;
    b.mid = mid[bbt_pkg::MID_W-1:0];
    b.up = up[bbt_pkg::BAND_W-1:0];
    b.dn = dn[bbt_pkg::BAND_W-1:0];
    if (c > up) b.sig = bbt_pkg::SIG_OVERBOUGHT;
    else if (off <= mid && c < dn) b.sig = bbt_pkg::SIG_OVERSOLD;
    else if (c > mid) b.sig = bbt_pkg::SIG_BULLISH;
    else b.sig = bbt_pkg::SIG_BEARISH;
    return b;
  endfunction

  task automatic send_price(logic [bbt_pkg::PRICE_BITS-1:0] price, logic start, bit fixed,
                            band_t res);
    band_t b;
    int gap;
    gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    close_price_i <= price;
    start_series_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    b = predict_band(price, start);
    band_q.insert(band_q.size(), fixed ? res : b);
  endtask

  task automatic write_reg(logic [bbt_pkg::CFG_IDX_W-1:0] idx,
                           logic [bbt_pkg::CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    while (band_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_cfg(idx, data);
  endtask

  function automatic void add_cfg(logic [bbt_pkg::CFG_IDX_W-1:0] idx,
                                  logic [bbt_pkg::CFG_DATA_W-1:0] data);
    row_t r;
    r.is_cfg = 1;
    r.idx = idx;
    r.data = data;
    r.price = '0;
    r.start = 1'b0;
    r.fixed = 0;
    r.res = '{'0, '0, '0, bbt_pkg::SIG_NONE};
    rows.insert(rows.size(), r);
  endfunction

  function automatic void add_item(logic [bbt_pkg::PRICE_BITS-1:0] price, logic start,
                                   bit fixed, logic [bbt_pkg::MID_W-1:0] mid,
                                   logic signed [bbt_pkg::BAND_W-1:0] up,
                                   logic signed [bbt_pkg::BAND_W-1:0] dn,
                                   bbt_pkg::signal_e sig);
    row_t r;
    r.is_cfg = 0;
    r.idx = '0;
    r.data = '0;
    r.price = price;
    r.start = start;
    r.fixed = fixed;
    r.res = '{mid, up, dn, sig};
    rows.insert(rows.size(), r);
  endfunction

  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= $urandom_range(1, 14) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    band_t e;
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (band_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        e = band_q.pop_front();
        if (middle_band_o !== e.mid) begin
          $error("middle_band expected %0d actual %0d", e.mid, middle_band_o);
          errors++;
        end
        if (band_up_o !== e.up) begin
          $error("band_up expected %0d actual %0d", e.up, band_up_o);
          errors++;
        end
        if (band_dn_o !== e.dn) begin
          $error("band_dn expected %0d actual %0d", e.dn, band_dn_o);
          errors++;
        end
        if (band_signal_o !== e.sig) begin
          $error("band_signal expected %0d actual %0d", e.sig, band_signal_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int n, per, mode;
    logic [bbt_pkg::PRICE_BITS-1:0] base, px;
    clear_series();
    add_item(24'd100, 1'b0, 1, '0, '0, '0, bbt_pkg::SIG_NONE);
    add_item(24'hFFFFFF, 1'b0, 1, '0, '0, '0, bbt_pkg::SIG_NONE);
    add_cfg(bbt_pkg::REG_BANDW, 9'd255);
    add_cfg(bbt_pkg::REG_PERIOD, 9'd0);
    add_item(24'd0, 1'b0, 1, '0, '0, '0, bbt_pkg::SIG_BEARISH);
    add_item(24'hFFFFFF, 1'b0, 1, 32'hFFFFFF00, 41'hFFFFFF00, 41'hFFFFFF00,
             bbt_pkg::SIG_BEARISH);
    add_item(24'd1, 1'b1, 1, 32'd256, 41'd256, 41'd256, bbt_pkg::SIG_BEARISH);
    add_cfg(2'd2, 9'd5);
    add_cfg(2'd3, 9'h1FF);
    add_cfg(bbt_pkg::REG_PERIOD, 9'd2);
    add_cfg(bbt_pkg::REG_BANDW, 9'd32);
    add_item(24'd0, 1'b0, 1, '0, '0, '0, bbt_pkg::SIG_NONE);
    add_item(24'hFFFFFF, 1'b0, 0, '0, '0, '0, bbt_pkg::SIG_NONE);
    add_item(24'd0, 1'b0, 0, '0, '0, '0, bbt_pkg::SIG_NONE);
    add_item(24'd5, 1'b1, 1, '0, '0, '0, bbt_pkg::SIG_NONE);
    add_item(24'd7, 1'b0, 0, '0, '0, '0, bbt_pkg::SIG_NONE);
    add_cfg(bbt_pkg::REG_BANDW, 9'd0);
    add_item(24'd9, 1'b0, 0, '0, '0, '0, bbt_pkg::SIG_NONE);
    add_cfg(bbt_pkg::REG_PERIOD, 9'h1FF);
    add_cfg(bbt_pkg::REG_BANDW, 9'd16);
    add_item(24'd3, 1'b0, 1, '0, '0, '0, bbt_pkg::SIG_NONE);
    add_cfg(bbt_pkg::REG_PERIOD, 9'd3);
    add_item(24'd10, 1'b0, 0, '0, '0, '0, bbt_pkg::SIG_NONE);
    add_item(24'd20, 1'b0, 0, '0, '0, '0, bbt_pkg::SIG_NONE);
    add_item(24'd30, 1'b0, 0, '0, '0, '0, bbt_pkg::SIG_NONE);
    add_item(24'd40, 1'b0, 0, '0, '0, '0, bbt_pkg::SIG_NONE);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].data);
      else send_price(rows[i].price, rows[i].start, rows[i].fixed, rows[i].res);
    end

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) quiet = 1;
      case ($urandom_range(0, 9))
        0: per = $urandom_range(256, 511);
        1: per = $urandom_range(0, 1);
        default: per = $urandom_range(2, 40);
      endcase
      write_reg(bbt_pkg::REG_PERIOD, 9'(per));
      case ($urandom_range(0, 3))
        0: write_reg(bbt_pkg::REG_BANDW, 9'd0);
        1: write_reg(bbt_pkg::REG_BANDW, 9'd255);
        default: write_reg(bbt_pkg::REG_BANDW, {1'($urandom_range(0, 1)), 8'($urandom)});
      endcase
      if ($urandom_range(0, 2) == 0) write_reg(2'($urandom_range(2, 3)), 9'($urandom));
      n = (per >= 200) ? 300 : 100;
      mode = $urandom_range(0, 1);
      base = 24'($urandom);
      for (int k = 0; k < n; k++) begin
        if (mode == 0) px = 24'($urandom);
        else px = base + 24'($urandom_range(0, 255)) - 24'd128;
        send_price(px, $urandom_range(0, 39) == 0, 0, '{'0, '0, '0, bbt_pkg::SIG_NONE});
      end
    end
    in_valid_i <= 1'b0;

    while (band_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/bbt_pkg.sv
src/bbt_serial_div.sv
src/bbt_serial_sqrt.sv
src/bollinger_band_tracker.sv
verif/tb_bollinger_band_tracker.sv
